>>> src/swos_pkg.sv
// Shared types, constants and trig tables for the sweep object segmenter.
package swos_pkg;

	localparam int MAX_OBJECTS   = 6;
	localparam int SWEEP_SAMPLES = 91;

	localparam logic [15:0] IR_START_RST = 16'd1120;
	localparam logic [15:0] PING_RST     = 16'd800;
	localparam logic [15:0] IR_NEXT_RST  = 16'd1600;
	localparam logic [15:0] SEED_RST     = 16'd1600;

	localparam int          ARC_NUM   = 157;
	localparam longint      ARC_DEN   = 4500;
	localparam int          ARC_SHIFT = 44;
	localparam logic [31:0] ARC_RECIP =
		32'(((64'd1 << ARC_SHIFT) + ARC_DEN - 64'd1) / ARC_DEN);

	localparam longint Q30_ONE     = 64'sd1073741824;
	localparam longint Q30_PI      = 64'sd3373259426;
	localparam longint Q30_HALF_PI = 64'sd1686629713;
	localparam longint DEG_SCALE   = 64'sd18000;
	localparam longint PI_X100     = 64'sd314;

	localparam longint COS_DIV [12] = '{
		64'sd2, 64'sd12, 64'sd30, 64'sd56, 64'sd90, 64'sd132,
		64'sd182, 64'sd240, 64'sd306, 64'sd380, 64'sd462, 64'sd552
	};
	localparam longint SIN_DIV [12] = '{
		64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110, 64'sd156,
		64'sd210, 64'sd272, 64'sd342, 64'sd420, 64'sd506, 64'sd600
	};

	typedef struct packed {
		logic [15:0] ir_dist;
		logic [15:0] ping_dist;
		logic        last_sample;
	} item_t;

	typedef struct packed {
		logic               object_valid;
		logic               sweep_done;
		logic [2:0]         object_number;
		logic [15:0]        distance;
		logic [7:0]         center_deg;
		logic [15:0]        arc_width;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
	} result_t;

	typedef struct packed {
		logic [15:0] ir_start_limit;
		logic [15:0] ping_limit;
		logic [15:0] ir_next_limit;
		logic [15:0] min_dist_seed;
	} cfg_t;

	typedef enum logic [1:0] {
		REG_IR_START = 2'd0,
		REG_PING     = 2'd1,
		REG_IR_NEXT  = 2'd2,
		REG_SEED     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic        obj;
		logic        done;
		logic [2:0]  number;
		logic [15:0] min_dist;
		logic [6:0]  run;
		logic [7:0]  center;
	} rec_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL1,
		B_MUL2,
		B_RECIP,
		B_SAT,
		B_POS,
		B_OUT
	} back_state_t;

	typedef logic signed [31:0] trig_tab_t [256];

	function automatic trig_tab_t build_trig(input logic want_sin);
		trig_tab_t tab;
		longint    t;
		longint    csign;
		longint    x2;
		longint    ct;
		longint    st;
		longint    csum;
		longint    ssum;
		for (int deg = 0; deg < 256; deg++) begin
			t = (longint'(deg) * PI_X100 * Q30_ONE) / DEG_SCALE;
			csign = 1;
			if (t > Q30_HALF_PI) begin
				t = Q30_PI - t;
				csign = -1;
			end
			x2   = (t * t) / Q30_ONE;
			ct   = Q30_ONE;
			csum = ct;
			st   = t;
			ssum = st;
			for (int n = 1; n <= 12; n++) begin
				ct   = ((-ct * x2) / Q30_ONE) / COS_DIV[n - 1];
				csum = csum + ct;
				st   = ((-st * x2) / Q30_ONE) / SIN_DIV[n - 1];
				ssum = ssum + st;
			end
			tab[deg] = want_sin ? 32'(ssum) : 32'(csign * csum);
		end
		return tab;
	endfunction

	localparam trig_tab_t COS_TAB = build_trig(1'b0);
	localparam trig_tab_t SIN_TAB = build_trig(1'b1);

endpackage

>>> src/swos_fifo.sv
// Two-entry queue of registers, generic in its payload type.
module swos_fifo #(
	parameter type item_t = logic
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  item_t wdata,
	output logic  full,
	input  logic  rd,
	output item_t rdata,
	output logic  empty
);

	item_t      ent_q [2];
	logic [1:0] count_q;
	logic       rd_ptr_q;
	logic       wr_ptr_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign rdata = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
		end else begin
			if (wr)
				wr_ptr_q <= ~wr_ptr_q;
			if (rd)
				rd_ptr_q <= ~rd_ptr_q;
			if (wr && !rd)
				count_q <= count_q + 2'd1;
			else if (rd && !wr)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			ent_q[wr_ptr_q] <= wdata;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> (!full || rd))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> !empty)
		else $error("queue read while empty");

endmodule

>>> src/swos_front.sv
// Front end: holds one sample for lookahead, segments objects, emits records.
module swos_front (
	input  logic            clk,
	input  logic            arst_n,
	input  swos_pkg::cfg_t  cfg,
	input  logic            acc,
	input  swos_pkg::item_t item,
	output logic            rec_push,
	output swos_pkg::rec_t  rec
);

	logic [15:0] held_ir_q, held_ir_d;
	logic [15:0] held_ping_q, held_ping_d;
	logic        have_held_q, have_held_d;
	logic [6:0]  idx_q, idx_d;
	logic        in_obj_q, in_obj_d;
	logic [6:0]  run_q, run_d;
	logic [15:0] run_min_q, run_min_d;
	logic [2:0]  found_q, found_d;

	logic       lastx;
	logic       active;
	logic       start;
	logic       close;
	logic       clear;
	logic [7:0] two_i;
	logic [7:0] run_ext;
	logic [7:0] center;

	always_comb begin
		two_i   = {idx_q, 1'b0};
		run_ext = {1'b0, run_q};
		center  = (run_ext > two_i) ? 8'd0 : (two_i - run_ext);
		lastx   = item.last_sample ||
			(({1'b0, idx_q} + 8'd1) >= 8'(swos_pkg::SWEEP_SAMPLES - 1));
		active  = (found_q < 3'(swos_pkg::MAX_OBJECTS));
		start   = !in_obj_q && (held_ir_q < cfg.ir_start_limit) &&
			(held_ping_q < cfg.ping_limit) &&
			(item.ir_dist < cfg.ir_next_limit) && (item.ping_dist != 16'd0);
		close   = in_obj_q &&
			((held_ir_q >= cfg.ir_start_limit) || (held_ping_q >= cfg.ping_limit));

		held_ir_d   = held_ir_q;
		held_ping_d = held_ping_q;
		have_held_d = have_held_q;
		idx_d       = idx_q;
		in_obj_d    = in_obj_q;
		run_d       = run_q;
		run_min_d   = run_min_q;
		found_d     = found_q;
		clear       = 1'b0;
		rec_push    = 1'b0;
		rec         = '0;
		rec.number  = found_q;

		if (acc) begin
			if (!have_held_q) begin
				if (item.last_sample) begin
					rec.done = 1'b1;
					rec_push = 1'b1;
					clear    = 1'b1;
				end else begin
					held_ir_d   = item.ir_dist;
					held_ping_d = item.ping_dist;
					have_held_d = 1'b1;
					idx_d       = 7'd0;
				end
			end else begin
				if (active) begin
					if (close) begin
						rec.obj      = 1'b1;
						rec.min_dist = run_min_q;
						rec.run      = run_q;
						rec.center   = center;
						rec_push     = 1'b1;
						found_d      = found_q + 3'd1;
						in_obj_d     = 1'b0;
						run_d        = 7'd0;
						run_min_d    = cfg.min_dist_seed;
					end else if (in_obj_q || start) begin
						in_obj_d = 1'b1;
						run_d    = run_q + 7'd1;
						if (held_ping_q < run_min_q)
							run_min_d = held_ping_q;
					end
				end
				if (lastx) begin
					rec.done = 1'b1;
					rec_push = 1'b1;
					clear    = 1'b1;
				end else begin
					held_ir_d   = item.ir_dist;
					held_ping_d = item.ping_dist;
					idx_d       = idx_q + 7'd1;
				end
			end
		end

		if (clear) begin
			held_ir_d   = 16'd0;
			held_ping_d = 16'd0;
			have_held_d = 1'b0;
			idx_d       = 7'd0;
			in_obj_d    = 1'b0;
			run_d       = 7'd0;
			run_min_d   = cfg.min_dist_seed;
			found_d     = 3'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_ir_q   <= 16'd0;
			held_ping_q <= 16'd0;
			have_held_q <= 1'b0;
			idx_q       <= 7'd0;
			in_obj_q    <= 1'b0;
			run_q       <= 7'd0;
			run_min_q   <= swos_pkg::SEED_RST;
			found_q     <= 3'd0;
		end else begin
			held_ir_q   <= held_ir_d;
			held_ping_q <= held_ping_d;
			have_held_q <= have_held_d;
			idx_q       <= idx_d;
			in_obj_q    <= in_obj_d;
			run_q       <= run_d;
			run_min_q   <= run_min_d;
			found_q     <= found_d;
		end
	end

	a_found_limit: assert property (@(posedge clk) disable iff (!arst_n)
		found_q <= 3'(swos_pkg::MAX_OBJECTS))
		else $error("object count beyond limit");
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_push && rec.done) |=> (!have_held_q && !in_obj_q && found_q == 3'd0))
		else $error("sweep state not cleared after done");

endmodule

>>> src/swos_back.sv
// Back end: turns one record into a result over a fixed multiply sequence.
module swos_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rec_empty,
	input  swos_pkg::rec_t     rec,
	output logic               rec_pop,
	input  logic               res_full,
	output logic               res_push,
	output swos_pkg::result_t  res
);

	swos_pkg::back_state_t state_q, state_d;

	logic               obj_q;
	logic               done_q;
	logic [2:0]         num_q;
	logic [15:0]        dist_q;
	logic [6:0]         run_q;
	logic [7:0]         center_q;
	logic [30:0]        prod_q;
	logic [62:0]        quo_q;
	logic [15:0]        arc_q;
	logic [17:0]        rad_q;
	logic signed [31:0] cos_q;
	logic signed [31:0] sin_q;
	logic signed [50:0] px_q;
	logic signed [50:0] py_q;

	logic [22:0]        wd_prod;
	logic [15:0]        arc_sat;
	logic signed [50:0] rad_w;
	logic signed [50:0] cos_w;
	logic signed [50:0] sin_w;

	function automatic logic signed [15:0] pos_scale(input logic signed [50:0] p);
		logic signed [50:0] adj;
		logic signed [19:0] v;
		adj = p + (p[50] ? 51'sd2147483647 : 51'sd0);
		v   = adj[50:31];
		if (v > 20'sd32767)
			return 16'sh7FFF;
		else if (v < -20'sd32768)
			return 16'sh8000;
		else
			return v[15:0];
	endfunction

	assign wd_prod = {16'd0, run_q} * {7'd0, dist_q};
	assign arc_sat = (quo_q[62:60] != 3'd0) ? 16'hFFFF : quo_q[59:44];
	assign rad_w   = {33'd0, rad_q};
	assign cos_w   = {{19{cos_q[31]}}, cos_q};
	assign sin_w   = {{19{sin_q[31]}}, sin_q};

	always_comb begin
		res.object_valid  = obj_q;
		res.sweep_done    = done_q;
		res.object_number = num_q;
		res.distance      = dist_q;
		res.center_deg    = center_q;
		res.arc_width     = arc_q;
		res.pos_x         = pos_scale(px_q);
		res.pos_y         = pos_scale(py_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= swos_pkg::B_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		rec_pop  = 1'b0;
		res_push = 1'b0;
		unique case (state_q)
			swos_pkg::B_IDLE: begin
				if (!rec_empty) begin
					rec_pop = 1'b1;
					state_d = swos_pkg::B_MUL1;
				end
			end
			swos_pkg::B_MUL1:  state_d = swos_pkg::B_MUL2;
			swos_pkg::B_MUL2:  state_d = swos_pkg::B_RECIP;
			swos_pkg::B_RECIP: state_d = swos_pkg::B_SAT;
			swos_pkg::B_SAT:   state_d = swos_pkg::B_POS;
			swos_pkg::B_POS:   state_d = swos_pkg::B_OUT;
			swos_pkg::B_OUT: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = swos_pkg::B_IDLE;
				end
			end
			default: state_d = swos_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			swos_pkg::B_IDLE: begin
				if (rec_pop) begin
					obj_q    <= rec.obj;
					done_q   <= rec.done;
					num_q    <= rec.number;
					dist_q   <= rec.min_dist;
					run_q    <= rec.run;
					center_q <= rec.center;
				end
			end
			swos_pkg::B_MUL1: begin
				prod_q <= {8'd0, wd_prod};
				cos_q  <= swos_pkg::COS_TAB[center_q];
				sin_q  <= swos_pkg::SIN_TAB[center_q];
			end
			swos_pkg::B_MUL2: begin
				prod_q <= prod_q * 31'(swos_pkg::ARC_NUM);
			end
			swos_pkg::B_RECIP: begin
				quo_q <= {32'd0, prod_q} * {31'd0, swos_pkg::ARC_RECIP};
			end
			swos_pkg::B_SAT: begin
				arc_q <= arc_sat;
				rad_q <= {1'b0, dist_q, 1'b0} + {2'd0, arc_sat};
			end
			swos_pkg::B_POS: begin
				px_q <= rad_w * cos_w;
				py_q <= rad_w * sin_w;
			end
			default: begin
			end
		endcase
	end

	a_push_has_content: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (res.object_valid || res.sweep_done))
		else $error("result with neither object nor done");
	a_done_only_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && !res.object_valid) |->
		(res.distance == 16'd0 && res.arc_width == 16'd0 &&
		 res.pos_x == 16'sd0 && res.pos_y == 16'sd0))
		else $error("done result carries object data");

endmodule

>>> src/sweep_object_segmenter_top.sv
// Top level of the sweep object segmenter: config registers and queues.
//
//  channel   direction  handshake            payload
//  item      in         push / full          swos_pkg::item_t
//  result    out        pop / empty          swos_pkg::result_t
//  config    in         cfg_we               cfg_idx, cfg_data
//
// The front end takes one sample per cycle while the record queue has room.
// Each record (object or sweep done) occupies the back end for a pop,
//   five multiply and saturate steps, one per cycle, and a push.
// A result reaches the result ports through the record queue, the back end steps and the result queue.
// Reset is asynchronous; config returns to defaults, no clearing pass.
// A full result queue stalls the back end, which in turn fills the record
//   queue and raises full.
module sweep_object_segmenter_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  swos_pkg::item_t    item,
	input  logic               pop,
	output logic               empty,
	output swos_pkg::result_t  result,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [15:0]        cfg_data
);

	swos_pkg::cfg_t    cfg_q;
	swos_pkg::rec_t    front_rec;
	swos_pkg::rec_t    back_rec;
	swos_pkg::result_t back_res;
	logic              acc;
	logic              front_push;
	logic              rec_full;
	logic              rec_empty;
	logic              rec_pop;
	logic              res_full;
	logic              res_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ir_start_limit <= swos_pkg::IR_START_RST;
			cfg_q.ping_limit     <= swos_pkg::PING_RST;
			cfg_q.ir_next_limit  <= swos_pkg::IR_NEXT_RST;
			cfg_q.min_dist_seed  <= swos_pkg::SEED_RST;
		end else if (cfg_we) begin
			unique case (swos_pkg::cfg_reg_t'(cfg_idx))
				swos_pkg::REG_IR_START: cfg_q.ir_start_limit <= cfg_data;
				swos_pkg::REG_PING:     cfg_q.ping_limit     <= cfg_data;
				swos_pkg::REG_IR_NEXT:  cfg_q.ir_next_limit  <= cfg_data;
				swos_pkg::REG_SEED:     cfg_q.min_dist_seed  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign full = rec_full;
	assign acc  = push && !rec_full;

	swos_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.acc      (acc),
		.item     (item),
		.rec_push (front_push),
		.rec      (front_rec)
	);

	swos_fifo #(
		.item_t (swos_pkg::rec_t)
	) u_rec_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (front_push),
		.wdata  (front_rec),
		.full   (rec_full),
		.rd     (rec_pop),
		.rdata  (back_rec),
		.empty  (rec_empty)
	);

	swos_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_empty (rec_empty),
		.rec       (back_rec),
		.rec_pop   (rec_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (back_res)
	);

	swos_fifo #(
		.item_t (swos_pkg::result_t)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_push),
		.wdata  (back_res),
		.full   (res_full),
		.rd     (pop && !empty),
		.rdata  (result),
		.empty  (empty)
	);

endmodule
